>>> src/running_average_background_top_macros.svh
// Assertion macros shared by the running average background RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef RUNNING_AVERAGE_BACKGROUND_TOP_MACROS_SVH
`define RUNNING_AVERAGE_BACKGROUND_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define RABG_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rabg assertion failed");

// condition must never be seen outside reset
`define RABG_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rabg forbidden condition seen");

`else

`define RABG_ASSERT(label, prop)
`define RABG_ASSERT_NEVER(label, cond)

`endif

`endif

>>> src/rabg_pkg.sv
// Shared types, register codes and the grey conversion for the running
// average background block. No dependencies.
package rabg_pkg;

    localparam int PIX_W       = 8;
    localparam int DIM_W       = 10;
    localparam int GAMMA_CFG_W = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int TOT_W       = 2 * DIM_W;
    localparam int Q_DEPTH     = 2;

    // BT.601 luma weights in Q14
    localparam int W_RED       = 4899;
    localparam int W_GREEN     = 9617;
    localparam int W_BLUE      = 1868;
    localparam int GREY_ROUND  = 8192;
    localparam int GREY_SHIFT  = 14;
    localparam int GREY_SUM_W  = GREY_SHIFT + PIX_W;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_GAMMA_Q8     = 2'd2
    } reg_idx_t;

    // per-pixel control carried from front to back
    typedef struct packed {
        logic [PIX_W-1:0] grey;
        logic             hold;
        logic             first;
        logic             last;
    } tag_t;

    // rounded grey level from one colour pixel
    function automatic logic [PIX_W-1:0] grey_of(
        input logic [PIX_W-1:0] r,
        input logic [PIX_W-1:0] g,
        input logic [PIX_W-1:0] b
    );
        logic [GREY_SUM_W-1:0] acc;
        acc = GREY_SUM_W'(r) * GREY_SUM_W'(W_RED)
            + GREY_SUM_W'(g) * GREY_SUM_W'(W_GREEN)
            + GREY_SUM_W'(b) * GREY_SUM_W'(W_BLUE)
            + GREY_SUM_W'(GREY_ROUND);
        return acc[GREY_SHIFT +: PIX_W];
    endfunction

endpackage

>>> src/rabg_pixel_if.sv
// Pixel input channel: valid/ready handshake with one colour word.
// Depends on rabg_pkg.
interface rabg_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [rabg_pkg::PIX_W-1:0]  blue;
    logic [rabg_pkg::PIX_W-1:0]  green;
    logic [rabg_pkg::PIX_W-1:0]  red;
    logic                        hold;

    modport source (output valid, blue, green, red, hold, input ready);
    modport sink   (input valid, blue, green, red, hold, output ready);
endinterface

>>> src/rabg_bg_if.sv
// Background result channel: valid/ready handshake, grey level and frame end.
// Depends on rabg_pkg.
interface rabg_bg_if;
    logic                        valid;
    logic                        ready;
    logic [rabg_pkg::PIX_W-1:0]  background;
    logic                        last_of_frame;

    modport source (output valid, background, last_of_frame, input ready);
    modport sink   (input valid, background, last_of_frame, output ready);
endinterface

>>> src/rabg_cfg_if.sv
// Configuration write channel: valid/ready handshake, register index and data.
// Depends on rabg_pkg.
interface rabg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rabg_pkg::CFG_IDX_W-1:0]   index;
    logic [rabg_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/rabg_front.sv
// Front end: configuration registers, scan position, frame tracking and grey
// conversion. Depends on rabg_pkg, the pixel and cfg interfaces and the macros.
`include "running_average_background_top_macros.svh"

module rabg_front #(
    parameter int  MAX_WIDTH       = 512,
    parameter int  MAX_HEIGHT      = 512,
    parameter int  GAMMA_FRAC_BITS = 8,
    localparam int DEPTH           = MAX_WIDTH * MAX_HEIGHT,
    localparam int ADDR_W          = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    rabg_pixel_if.sink                 pixel,
    rabg_cfg_if.sink                   cfg,
    output logic                       push_valid,
    input  logic                       push_ready,
    output logic [ADDR_W-1:0]          push_addr,
    output rabg_pkg::tag_t             push_tag,
    output logic [GAMMA_FRAC_BITS:0]   gamma_eff
);

    localparam int CMP_W   = ((ADDR_W > rabg_pkg::TOT_W) ? ADDR_W : rabg_pkg::TOT_W) + 1;
    localparam int DIM_MAX = (1 << rabg_pkg::DIM_W) - 1;
    localparam int W_LIM   = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
    localparam int H_LIM   = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
    localparam int GAM_W   = (GAMMA_FRAC_BITS + 1 > rabg_pkg::GAMMA_CFG_W) ?
                             GAMMA_FRAC_BITS + 1 : rabg_pkg::GAMMA_CFG_W;
    localparam int GAMMA_RESET = (9 * (1 << GAMMA_FRAC_BITS) + 5) / 10;
    localparam logic [GAM_W-1:0] GAMMA_ONE = GAM_W'(1) << GAMMA_FRAC_BITS;

    logic [rabg_pkg::DIM_W-1:0] width_reg;
    logic [rabg_pkg::DIM_W-1:0] height_reg;
    logic [GAM_W-1:0]           gamma_reg;
    logic                       cfg_hold_reg;
    logic [rabg_pkg::TOT_W-1:0] total_reg;
    logic [ADDR_W-1:0]          idx_reg;
    logic [ADDR_W-1:0]          idx_next;
    logic                       have_ref_reg;
    logic [rabg_pkg::DIM_W-1:0] width_eff;
    logic [rabg_pkg::DIM_W-1:0] height_eff;
    logic [GAM_W-1:0]           gamma_sat;
    logic                       accept;
    logic                       last;

    // configuration writes; unknown indexes are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rabg_pkg::DIM_W'(512);
            height_reg <= rabg_pkg::DIM_W'(512);
            gamma_reg  <= GAM_W'(GAMMA_RESET);
        end
        else if (cfg.valid)
        begin
            case (rabg_pkg::reg_idx_t'(cfg.index))
                rabg_pkg::REG_FRAME_WIDTH:
                    width_reg <= cfg.data[rabg_pkg::DIM_W-1:0];
                rabg_pkg::REG_FRAME_HEIGHT:
                    height_reg <= cfg.data[rabg_pkg::DIM_W-1:0];
                rabg_pkg::REG_GAMMA_Q8:
                    gamma_reg <= GAM_W'(cfg.data[rabg_pkg::GAMMA_CFG_W-1:0]);
                default:
                    ;
            endcase
        end
    end

    // clamp sizes to 1..max and gamma to one
    always_comb
    begin
        if (width_reg == '0)
            width_eff = rabg_pkg::DIM_W'(1);
        else if (width_reg > rabg_pkg::DIM_W'(W_LIM))
            width_eff = rabg_pkg::DIM_W'(W_LIM);
        else
            width_eff = width_reg;

        if (height_reg == '0)
            height_eff = rabg_pkg::DIM_W'(1);
        else if (height_reg > rabg_pkg::DIM_W'(H_LIM))
            height_eff = rabg_pkg::DIM_W'(H_LIM);
        else
            height_eff = height_reg;

        gamma_sat = (gamma_reg > GAMMA_ONE) ? GAMMA_ONE : gamma_reg;
    end

    assign gamma_eff = gamma_sat[GAMMA_FRAC_BITS:0];

    // frame size product, re-registered every cycle; pixels pause in the cycle
    // after any config write so the product has settled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            cfg_hold_reg <= 1'b1;
        end
        else
        begin
            total_reg    <= rabg_pkg::TOT_W'(width_eff) * rabg_pkg::TOT_W'(height_eff);
            cfg_hold_reg <= cfg.valid;
        end
    end

    // handshake: a pixel goes straight into the queue
    assign pixel.ready = push_ready && !cfg_hold_reg;
    assign push_valid  = pixel.valid && !cfg_hold_reg;
    assign accept      = pixel.valid && pixel.ready;

    // end of frame, also when the frame shrank below the scan position
    assign last = (CMP_W'(idx_reg) + CMP_W'(1)) >= CMP_W'(total_reg);

    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
            idx_next = last ? '0 : idx_reg + ADDR_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            have_ref_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (accept && last)
                have_ref_reg <= 1'b1;
        end
    end

    // word handed to the back end
    assign push_addr      = idx_reg;
    assign push_tag.grey  = rabg_pkg::grey_of(pixel.red, pixel.green, pixel.blue);
    assign push_tag.hold  = pixel.hold;
    assign push_tag.first = !have_ref_reg;
    assign push_tag.last  = last;

    `RABG_ASSERT(a_cfg_pauses_pixels, cfg.valid && cfg.ready |=> !pixel.ready)
    `RABG_ASSERT(a_frame_end_rewinds, accept && last |=> idx_reg == '0)

endmodule

>>> src/rabg_queue.sv
// Short word queue between the front and back ends.
// Depends on rabg_pkg and the macros.
`include "running_average_background_top_macros.svh"

module rabg_queue #(
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  logic [DW-1:0] push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output logic [DW-1:0] pop_data
);

    localparam int PTR_W = (rabg_pkg::Q_DEPTH > 1) ? $clog2(rabg_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(rabg_pkg::Q_DEPTH + 1);

    logic [DW-1:0]    slot_reg [rabg_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = count_reg != CNT_W'(rabg_pkg::Q_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(rabg_pkg::Q_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(rabg_pkg::Q_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    `RABG_ASSERT_NEVER(a_q_overflow, count_reg > CNT_W'(rabg_pkg::Q_DEPTH))
    `RABG_ASSERT(a_q_ptrs_agree, count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)

endmodule

>>> src/rabg_back.sv
// Back end: background store, blend and output register.
// Depends on rabg_pkg, the result interface and the macros.
`include "running_average_background_top_macros.svh"

module rabg_back #(
    parameter int  MAX_WIDTH       = 512,
    parameter int  MAX_HEIGHT      = 512,
    parameter int  GAMMA_FRAC_BITS = 8,
    localparam int DEPTH           = MAX_WIDTH * MAX_HEIGHT,
    localparam int ADDR_W          = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  logic [ADDR_W-1:0]         pop_addr,
    input  rabg_pkg::tag_t            pop_tag,
    input  logic [GAMMA_FRAC_BITS:0]  gamma_eff,
    rabg_bg_if.source                 result
);

    localparam int G_W    = GAMMA_FRAC_BITS + 1;
    localparam int BL_W   = G_W + rabg_pkg::PIX_W + 1;
    localparam logic [G_W-1:0] ONE = G_W'(1) << GAMMA_FRAC_BITS;

    logic [rabg_pkg::PIX_W-1:0] mem [DEPTH];

    logic                       s1_valid_reg;
    logic [ADDR_W-1:0]          s1_addr_reg;
    rabg_pkg::tag_t             s1_tag_reg;
    logic [rabg_pkg::PIX_W-1:0] rdata_reg;
    logic                       byp_reg;
    logic [rabg_pkg::PIX_W-1:0] byp_data_reg;
    logic                       out_valid_reg;
    logic [rabg_pkg::PIX_W-1:0] out_bg_reg;
    logic                       out_last_reg;

    logic                       s1_fire;
    logic                       pop;
    logic                       wr_en;
    logic [rabg_pkg::PIX_W-1:0] old_bg;
    logic [G_W-1:0]             inv_gamma;
    logic [BL_W-1:0]            blend;
    logic [rabg_pkg::PIX_W-1:0] new_bg;

    // stage control
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign pop_ready = !s1_valid_reg || s1_fire;
    assign pop       = pop_valid && pop_ready;
    assign wr_en     = s1_fire && (s1_tag_reg.first || !s1_tag_reg.hold);

    // store read, one address per word
    always_ff @(posedge clk)
    begin
        if (pop)
            rdata_reg <= mem[pop_addr];
    end

    // store write
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[s1_addr_reg] <= new_bg;
    end

    // read stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else if (pop_ready)
        begin
            s1_valid_reg <= pop_valid;
            byp_reg      <= pop_valid && wr_en && (pop_addr == s1_addr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_addr_reg  <= pop_addr;
            s1_tag_reg   <= pop_tag;
            byp_data_reg <= new_bg;
        end
    end

    // forward a write that landed on the same edge as our read
    assign old_bg    = byp_reg ? byp_data_reg : rdata_reg;
    assign inv_gamma = ONE - gamma_eff;
    assign blend     = BL_W'(gamma_eff) * BL_W'(old_bg)
                     + BL_W'(inv_gamma) * BL_W'(s1_tag_reg.grey);

    always_comb
    begin
        if (s1_tag_reg.first)
            new_bg = s1_tag_reg.grey;
        else if (s1_tag_reg.hold)
            new_bg = old_bg;
        else
            new_bg = blend[GAMMA_FRAC_BITS +: rabg_pkg::PIX_W];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_bg_reg   <= new_bg;
            out_last_reg <= s1_tag_reg.last;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.background    = out_bg_reg;
    assign result.last_of_frame = out_last_reg;

    `RABG_ASSERT(a_bypass_live_word, byp_reg |-> s1_valid_reg)

endmodule

>>> src/running_average_background_top.sv
// Top level of the running average background block.
// Depends on rabg_pkg, the three channel interfaces, rabg_front, rabg_queue, rabg_back.

// Takes one colour pixel word per clock in raster order, unless held by
// result back-pressure or a configuration pause, and returns one background
// word per pixel, in order, with last_of_frame on the final pixel of each
// frame. Sustained rate is one pixel per cycle while result is ready. A result
// passes the queue, the store read register and the output register before
// it is offered. The background store is a single memory of MAX_WIDTH*MAX_HEIGHT
// bytes with one read and one write port, read into a register ahead of the
// blend with same-address forwarding. It is not cleared: the first frame after
// reset writes every entry it uses. The pixel input drops ready in the cycle
// after any configuration write while the frame size product is re-registered.
// Configuration must only be written while no pixel is in flight.
module running_average_background_top #(
    parameter int MAX_WIDTH       = 512,
    parameter int MAX_HEIGHT      = 512,
    parameter int GAMMA_FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    rabg_pixel_if.sink  pixel,
    rabg_bg_if.source   result,
    rabg_cfg_if.sink    cfg
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TAG_W  = $bits(rabg_pkg::tag_t);
    localparam int DW     = ADDR_W + TAG_W;

    logic                      push_valid;
    logic                      push_ready;
    logic [ADDR_W-1:0]         push_addr;
    rabg_pkg::tag_t            push_tag;
    logic                      pop_valid;
    logic                      pop_ready;
    logic [DW-1:0]             pop_data;
    logic [GAMMA_FRAC_BITS:0]  gamma_eff;

    // front: config, scan position and grey conversion
    rabg_front #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .GAMMA_FRAC_BITS (GAMMA_FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_addr  (push_addr),
        .push_tag   (push_tag),
        .gamma_eff  (gamma_eff)
    );

    // decoupling queue
    rabg_queue #(
        .DW (DW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_addr, push_tag}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back: store, blend and result
    rabg_back #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .GAMMA_FRAC_BITS (GAMMA_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_addr  (pop_data[DW-1:TAG_W]),
        .pop_tag   (rabg_pkg::tag_t'(pop_data[TAG_W-1:0])),
        .gamma_eff (gamma_eff),
        .result    (result)
    );

endmodule
